>>> rtl/n2a_pkg.sv
// Shared types, constants and the control store of the number-to-ASCII formatter.
// Used by n2a_seq, number_to_ascii_formatter_top and tb_top; depends on nothing else.
`timescale 1ns / 1ps

package n2a_pkg;

    // Formatting limits.
    localparam int MAX_DEC_DIGITS = 9;
    localparam int MAX_HEX_DIGITS = 8;

    // Field widths.
    localparam int VAL_W  = 32;
    localparam int HEXW_W = 4;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = 4;
    localparam int WIDE_W = 34;   // holds 9 * 10^9
    localparam int DEC_N  = 10;   // decimal positions of a 32-bit value

    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

    typedef enum logic [1:0] {
        REQ_CHAR   = 2'd0,
        REQ_HEX_LO = 2'd1,
        REQ_HEX_UP = 2'd2,
        REQ_DEC    = 2'd3
    } t_req;

    // Control store addresses.
    typedef enum logic [2:0] {
        STEP_FETCH = 3'd0,
        STEP_CHR   = 3'd1,
        STEP_CRT   = 3'd2,
        STEP_HEX   = 3'd3,
        STEP_DCNT  = 3'd4,
        STEP_DDIG  = 3'd5,
        STEP_DERR  = 3'd6
    } t_step;

    typedef enum logic [2:0] {
        SRC_CHAR = 3'd0,
        SRC_CR   = 3'd1,
        SRC_HEX  = 3'd2,
        SRC_DEC  = 3'd3,
        SRC_ERR  = 3'd4
    } t_src;

    typedef enum logic [1:0] {
        CNT_HOLD     = 2'd0,
        CNT_LOAD_HEX = 2'd1,
        CNT_LOAD_DEC = 2'd2,
        CNT_DECR     = 2'd3
    } t_cnt_op;

    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,  // fall through
        COND_GOTO     = 3'd1,  // unconditional jump
        COND_LOOP     = 3'd2,  // jump while the counter is nonzero, else fetch
        COND_CHAR     = 3'd3,  // fall through on a line feed, else fetch
        COND_DISPATCH = 3'd4,  // jump by request type
        COND_ERR      = 3'd5   // jump when the decimal value is too long
    } t_cond;

    typedef struct packed {
        logic    accept;
        logic    emit;
        t_src    src;
        t_cnt_op cnt_op;
        logic    val_sub;
        t_cond   cond;
        t_step   target;
    } t_uword;

    // Status the sequencer branches and stalls on.
    typedef struct packed {
        logic s_valid;
        logic out_free;
        logic is_nl;
        logic cnt_zero;
        logic too_long;
        t_req req_type;
    } t_seq_flags;

    typedef logic [DEC_N-1:0][DEC_N-1:0][WIDE_W-1:0] t_mult_tbl;

    // Row i, column d holds d * 10^i.
    function automatic t_mult_tbl build_mult();
        t_mult_tbl tbl;
        longint unsigned w;
        w = 1;
        for (int i = 0; i < DEC_N; i++) begin
            for (int d = 0; d < DEC_N; d++) begin
                tbl[i][d] = WIDE_W'(w * longint'(d));
            end
            w = w * 10;
        end
        return tbl;
    endfunction

    localparam t_mult_tbl DEC_MULT = build_mult();

    // The microprogram.
    function automatic t_uword ucode_rom(input t_step a);
        t_uword w;
        w = '{accept: 1'b0, emit: 1'b0, src: SRC_CHAR, cnt_op: CNT_HOLD,
              val_sub: 1'b0, cond: COND_GOTO, target: STEP_FETCH};
        unique case (a)
            STEP_FETCH: begin
                w.accept = 1'b1;
                w.cnt_op = CNT_LOAD_HEX;
                w.cond   = COND_DISPATCH;
            end
            STEP_CHR: begin
                w.emit = 1'b1;
                w.src  = SRC_CHAR;
                w.cond = COND_CHAR;
            end
            STEP_CRT: begin
                w.emit = 1'b1;
                w.src  = SRC_CR;
            end
            STEP_HEX: begin
                w.emit   = 1'b1;
                w.src    = SRC_HEX;
                w.cnt_op = CNT_DECR;
                w.cond   = COND_LOOP;
                w.target = STEP_HEX;
            end
            STEP_DCNT: begin
                w.cnt_op = CNT_LOAD_DEC;
                w.cond   = COND_ERR;
                w.target = STEP_DERR;
            end
            STEP_DDIG: begin
                w.emit    = 1'b1;
                w.src     = SRC_DEC;
                w.cnt_op  = CNT_DECR;
                w.val_sub = 1'b1;
                w.cond    = COND_LOOP;
                w.target  = STEP_DDIG;
            end
            STEP_DERR: begin
                w.emit = 1'b1;
                w.src  = SRC_ERR;
            end
            default: begin
                w.cond = COND_GOTO;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/number_to_ascii_formatter_top.sv
// Top level of the number-to-ASCII formatter: datapath and output register.
// Depends on n2a_pkg and on n2a_seq, which steps through the control store.
`timescale 1ns / 1ps

// Usage:
// A request enters on the slave stream: tuser carries the request type (raw
// character, lower hex, upper hex or unsigned decimal), tdata the value and
// the hex width. The characters leave on the master stream one item per
// cycle while the receiver is ready, tlast marking the final character
// and tuser flagging a decimal value that has too many digits (that run is
// a single NUL character). The block works on one request at a time: a
// fetch step, a digit-count step in decimal mode, then one step per
// character (the error step for a too-long decimal). The rate is set by the
// single output register, which takes one character per cycle while the
// receiver is ready. The first character appears once its step (after the
// digit-count step for decimal) loads the output register.
// s_axis_tready is high only in the fetch step.
// When the receiver stalls, the current character waits in the output
// register and the sequencer holds its step; nothing is dropped.
// A synchronous reset returns the sequencer to the fetch step and empties
// the output register; the request registers carry payload and are not reset.
module number_to_ascii_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] value, [35:32] hex_width, rest zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] ascii_char
    output logic        m_axis_tlast,   // last
    output logic [0:0]  m_axis_tuser    // [0] error
);
    import n2a_pkg::*;

    // Request registers.
    logic [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]  n_val;
    t_req              r_type;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    // Output register.
    logic              r_m_valid;
    logic [CHAR_W-1:0] r_m_data;
    logic              r_m_last;
    logic              r_m_err;

    t_uword            uw;
    logic              fire;
    t_seq_flags        flags;

    logic [HEXW_W-1:0] in_width;
    logic [HEXW_W-1:0] eff_width;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] hex_ch;
    logic [CNT_W-1:0]  dec_d;
    logic [CNT_W-1:0]  dig_m1;
    logic [WIDE_W-1:0] val_wide;
    logic [WIDE_W-1:0] sub_amt;
    logic [CHAR_W-1:0] out_ch;
    logic              out_last;
    logic              is_nl;
    logic              too_long;

    n2a_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uw),
        .o_fire  (fire)
    );

    assign in_width = s_axis_tdata[VAL_W +: HEXW_W];
    assign val_wide = {{(WIDE_W-VAL_W){1'b0}}, r_val};
    assign is_nl    = (r_val[CHAR_W-1:0] == CHAR_LF);

    // A width of zero or any width beyond the widest hex field means full width.
    always_comb begin
        if (in_width == '0 || in_width > HEXW_W'(MAX_HEX_DIGITS)) begin
            eff_width = HEXW_W'(MAX_HEX_DIGITS);
        end else begin
            eff_width = in_width;
        end
    end

    // Hex digit at the counter position, most significant first.
    always_comb begin
        nib = 4'(r_val >> {r_cnt[2:0], 2'b00});
        if (nib < 4'd10) begin
            hex_ch = CHAR_ZERO + CHAR_W'(nib);
        end else if (r_type == REQ_HEX_UP) begin
            hex_ch = CHAR_UP_A + CHAR_W'(nib - 4'd10);
        end else begin
            hex_ch = CHAR_LO_A + CHAR_W'(nib - 4'd10);
        end
    end

    // Digit count: how many powers of ten from 10 up the value reaches.
    always_comb begin
        dig_m1 = '0;
        for (int i = 1; i < DEC_N; i++) begin
            dig_m1 = dig_m1 + CNT_W'(val_wide >= DEC_MULT[i][1]);
        end
        too_long = (dig_m1 >= CNT_W'(MAX_DEC_DIGITS));
    end

    // Decimal digit: the largest d with d * 10^cnt not above the value,
    // found by comparing against all nine multiples at once.
    always_comb begin
        dec_d = '0;
        for (int k = 1; k < DEC_N; k++) begin
            dec_d = dec_d + CNT_W'(val_wide >= DEC_MULT[r_cnt][k]);
        end
        sub_amt = DEC_MULT[r_cnt][dec_d];
    end

    always_comb begin
        case (uw.src)
            SRC_CHAR: begin
                out_ch   = r_val[CHAR_W-1:0];
                out_last = !is_nl;
            end
            SRC_CR: begin
                out_ch   = CHAR_CR;
                out_last = 1'b1;
            end
            SRC_HEX: begin
                out_ch   = hex_ch;
                out_last = (r_cnt == '0);
            end
            SRC_DEC: begin
                out_ch   = CHAR_ZERO + CHAR_W'(dec_d);
                out_last = (r_cnt == '0);
            end
            default: begin
                out_ch   = CHAR_NUL;
                out_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_val = r_val;
        if (uw.accept) begin
            n_val = s_axis_tdata[VAL_W-1:0];
        end else if (uw.val_sub) begin
            n_val = r_val - sub_amt[VAL_W-1:0];
        end
    end

    always_comb begin
        case (uw.cnt_op)
            CNT_LOAD_HEX: n_cnt = eff_width - 4'd1;
            CNT_LOAD_DEC: n_cnt = dig_m1;
            CNT_DECR:     n_cnt = r_cnt - 4'd1;
            default:      n_cnt = r_cnt;
        endcase
    end

    always_comb begin
        flags.s_valid  = s_axis_tvalid;
        flags.out_free = !r_m_valid || m_axis_tready;
        flags.is_nl    = is_nl;
        flags.cnt_zero = (r_cnt == '0);
        flags.too_long = too_long;
        flags.req_type = t_req'(s_axis_tuser);
    end

    // Request registers carry payload only.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_val <= n_val;
            r_cnt <= n_cnt;
            if (uw.accept) begin
                r_type <= t_req'(s_axis_tuser);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (fire && uw.emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && uw.emit) begin
            r_m_data <= out_ch;
            r_m_last <= out_last;
            r_m_err  <= (uw.src == SRC_ERR);
        end
    end

    assign s_axis_tready   = uw.accept;
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tlast    = r_m_last;
    assign m_axis_tuser[0] = r_m_err;

endmodule

>>> rtl/n2a_seq.sv
// Step counter and control-store sequencer of the number-to-ASCII formatter.
// Depends on n2a_pkg for the control word, the step codes and the ROM.
`timescale 1ns / 1ps

module n2a_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  n2a_pkg::t_seq_flags i_flags,
    output n2a_pkg::t_uword   o_uword,
    output logic              o_fire
);
    import n2a_pkg::*;

    t_step  r_upc;
    t_step  n_upc;
    t_uword uw;
    logic   fire;

    // Output decode: the control word of the current step.
    always_comb begin
        uw = ucode_rom(r_upc);
        if (uw.accept) begin
            fire = i_flags.s_valid;
        end else if (uw.emit) begin
            fire = i_flags.out_free;
        end else begin
            fire = 1'b1;
        end
    end

    // Next step.
    always_comb begin
        n_upc = r_upc;
        if (fire) begin
            unique case (uw.cond)
                COND_NEXT: n_upc = t_step'(r_upc + 3'd1);
                COND_GOTO: n_upc = uw.target;
                COND_LOOP: n_upc = i_flags.cnt_zero ? STEP_FETCH : uw.target;
                COND_CHAR: n_upc = i_flags.is_nl ? t_step'(r_upc + 3'd1) : STEP_FETCH;
                COND_ERR:  n_upc = i_flags.too_long ? uw.target : t_step'(r_upc + 3'd1);
                COND_DISPATCH: begin
                    unique case (i_flags.req_type) inside
                        REQ_CHAR:               n_upc = STEP_CHR;
                        REQ_HEX_LO, REQ_HEX_UP: n_upc = STEP_HEX;
                        REQ_DEC:                n_upc = STEP_DCNT;
                        default:                n_upc = STEP_FETCH;
                    endcase
                end
                default: n_upc = STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= STEP_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = uw;
    assign o_fire  = fire;

endmodule

>>> sim/tb_top.sv
// Testbench for number_to_ascii_formatter_top: directed and random requests with
// an independent character predictor and a scoreboard. Depends on n2a_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    import n2a_pkg::*;

    // The run is stopped here even if the block hangs; the slowest legal run is
    // far shorter.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 20;
    localparam int SETTLE_CYCLES = 16;   // idle time after draining, to catch stray output
    localparam int RANDOM_ITEMS  = 50;

    // One character as it leaves the block.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              err;
    } t_out_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // [31:0] value, [35:32] hex_width, rest zero
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] ascii_char
    logic        m_axis_tlast;   // last
    logic [0:0]  m_axis_tuser;   // [0] error

    // Characters predicted for accepted requests, oldest first.
    t_out_char   pending_chars[$];

    int          mismatches = 0;
    int          chars_checked = 0;
    int          requests_by_type[4] = '{0, 0, 0, 0};
    int          cycle_count = 0;

    // Random idling on each side can be switched off for back-to-back stretches.
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    // A long receiver hold, in cycles; the sink process waits it out and clears it.
    int          sink_hold_len = 0;

    number_to_ascii_formatter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d characters still expected",
                     cycle_count, pending_chars.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h",
                     $realtime, what, got, want);
        end
    endtask

    // Works out the characters that one accepted request must produce and
    // appends them to the scoreboard.
    task automatic queue_expected_chars(t_req rt, logic [31:0] v, logic [3:0] w);
        t_out_char   c;
        int          n_dig;
        int          digs[DEC_N];
        int unsigned rest;
        logic [3:0]  nib;
        c.err = 1'b0;
        case (rt)
            REQ_CHAR: begin
                // A line feed is followed by a carriage return, which closes the run.
                c.ch   = v[7:0];
                c.last = (v[7:0] != CHAR_LF);
                pending_chars.push_back(c);
                if (v[7:0] == CHAR_LF) begin
                    c.ch   = CHAR_CR;
                    c.last = 1'b1;
                    pending_chars.push_back(c);
                end
            end
            REQ_HEX_LO, REQ_HEX_UP: begin
                // Width zero or beyond the maximum means full width.
                n_dig = (w == 0 || w > MAX_HEX_DIGITS) ? MAX_HEX_DIGITS : int'(w);
                for (int i = n_dig - 1; i >= 0; i--) begin
                    nib = v[i*4 +: 4];
                    if (nib < 10) begin
                        c.ch = CHAR_ZERO + nib;
                    end else begin
                        c.ch = ((rt == REQ_HEX_LO) ? CHAR_LO_A : CHAR_UP_A) + nib - 10;
                    end
                    c.last = (i == 0);
                    pending_chars.push_back(c);
                end
            end
            default: begin
                if (v >= 32'd1000000000) begin
                    // Ten digits do not fit: one NUL character flagged as an error.
                    c.ch   = CHAR_NUL;
                    c.last = 1'b1;
                    c.err  = 1'b1;
                    pending_chars.push_back(c);
                end else begin
                    rest  = v;
                    n_dig = 0;
                    do begin
                        digs[n_dig] = rest % 10;
                        rest        = rest / 10;
                        n_dig++;
                    end while (rest != 0);
                    for (int i = n_dig - 1; i >= 0; i--) begin
                        c.ch   = CHAR_ZERO + digs[i];
                        c.last = (i == 0);
                        pending_chars.push_back(c);
                    end
                end
            end
        endcase
    endtask

    // Offers one request and returns at the edge where it is accepted. The
    // valid is left high so that a following request can go back to back; it
    // is lowered only by an idle gap or by park_source.
    task automatic send_request(t_req rt, logic [31:0] v, logic [3:0] w);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, w, v};
        s_axis_tuser  <= rt;
        do @(posedge i_clk); while (!s_axis_tready);
        queue_expected_chars(rt, v, w);
        requests_by_type[rt]++;
    endtask

    task automatic park_source();
        s_axis_tvalid <= 1'b0;
    endtask

    // Source stops and waits until every predicted character has come out.
    task automatic wait_drained();
        park_source();
        wait (pending_chars.size() == 0);
        @(posedge i_clk);
    endtask

    // One random request. Decimal values are spread over every digit count,
    // with full-range values (mostly ten digits, the error case) about one time in ten.
    task automatic send_random_request();
        t_req        rt;
        logic [31:0] v;
        int          k;
        int unsigned lo;
        int unsigned hi;
        rt = t_req'($urandom_range(0, 3));
        v  = $urandom;
        case (rt)
            REQ_CHAR: begin
                if ($urandom_range(0, 3) == 0) v[7:0] = CHAR_LF;
            end
            REQ_DEC: begin
                k = $urandom_range(1, 10);
                if (k < 10) begin
                    lo = 0;
                    hi = 9;
                    for (int i = 1; i < k; i++) begin
                        lo = (i == 1) ? 10 : lo * 10;
                        hi = hi * 10 + 9;
                    end
                    v = $urandom_range(hi, lo);
                end
            end
            default: begin
            end
        endcase
        send_request(rt, v, 4'($urandom_range(0, 15)));
    endtask

    // Receiver: draws a stall before each character, and takes a long hold
    // whenever one has been requested.
    initial begin : sink
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold_len > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_len) @(posedge i_clk);
                sink_hold_len = 0;
            end
            stall = sink_idle_on ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Scoreboard: every accepted character is compared with the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin : check_chars
        t_out_char want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character", m_axis_tdata, 0);
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_axis_tdata !== want.ch)
                    report_mismatch("ascii_char", m_axis_tdata, want.ch);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
                if (m_axis_tuser[0] !== want.err)
                    report_mismatch("error", m_axis_tuser[0], want.err);
            end
        end
    end

    // Raw characters: both byte extremes, a line feed (with and without upper
    // value bits set), a carriage return on its own and a letter with upper bits set.
    task automatic test_raw_chars();
        send_request(REQ_CHAR, 32'h0000_0000, 4'd0);
        send_request(REQ_CHAR, 32'h0000_00FF, 4'd15);
        send_request(REQ_CHAR, 32'h0000_000A, 4'd0);
        send_request(REQ_CHAR, 32'hFFFF_FF0A, 4'd7);
        send_request(REQ_CHAR, 32'h0000_000D, 4'd0);
        send_request(REQ_CHAR, 32'hA5A5_5A41, 4'd8);
    endtask

    // Hex in both cases: widths 0, 1, 3, 4, full, just above full and the field maximum.
    task automatic test_hex_digits();
        send_request(REQ_HEX_LO, 32'h89AB_CDEF, 4'd0);
        send_request(REQ_HEX_UP, 32'h89AB_CDEF, 4'd8);
        send_request(REQ_HEX_LO, 32'hFFFF_FFFF, 4'd1);
        send_request(REQ_HEX_UP, 32'hFFFF_FFFF, 4'd9);
        send_request(REQ_HEX_LO, 32'h0000_0000, 4'd15);
        send_request(REQ_HEX_UP, 32'h0000_0000, 4'd4);
        send_request(REQ_HEX_LO, 32'h0123_4567, 4'd3);
        send_request(REQ_HEX_UP, 32'hFEDC_BA98, 4'd0);
    endtask

    // Decimal: zero, one digit, the digit-count boundaries and the values
    // that are too long.
    task automatic test_decimal_limits();
        send_request(REQ_DEC, 32'd0, 4'd0);
        send_request(REQ_DEC, 32'd9, 4'd0);
        send_request(REQ_DEC, 32'd10, 4'd0);
        send_request(REQ_DEC, 32'd100000000, 4'd0);
        send_request(REQ_DEC, 32'd999999999, 4'd15);
        send_request(REQ_DEC, 32'd1000000000, 4'd0);
        send_request(REQ_DEC, 32'hFFFF_FFFF, 4'd0);
    endtask

    // The receiver holds off for a long stretch while the source keeps
    // offering, so the output register fills and the input stalls.
    task automatic test_output_stall();
        sink_hold_len = 80;
        repeat (12) send_random_request();
    endtask

    // The source pauses until all output has drained, then resumes.
    task automatic test_drain_pause();
        repeat (4) send_random_request();
        wait_drained();
    endtask

    // Neither side idles: requests and characters go back to back.
    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (16) send_random_request();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_ITEMS) send_random_request();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_raw_chars();
        test_hex_digits();
        test_decimal_limits();
        test_drain_pause();
        test_output_stall();
        test_back_to_back();
        test_random_mix();

        // Wait for the last run, then a few more cycles to catch stray output.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d char, %0d lower hex, %0d upper hex, %0d decimal requests",
                 requests_by_type[REQ_CHAR], requests_by_type[REQ_HEX_LO],
                 requests_by_type[REQ_HEX_UP], requests_by_type[REQ_DEC]);
        $display("checked %0d characters with %0d mismatches in %0d cycles",
                 chars_checked, mismatches, cycle_count);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/n2a_pkg.sv
rtl/n2a_seq.sv
rtl/number_to_ascii_formatter_top.sv
sim/tb_top.sv
